@@ hw/rtl/dpsc_pkg.sv @@
// Package for the distance PI speed controller.
// Field widths, register reset values, control structs and shared constants.
// No dependencies.
`timescale 1ns / 1ps

package dpsc_pkg;

  // Field and state widths
  localparam int DIST_W    = 13;
  localparam int TOL_W     = 10;
  localparam int SPDCFG_W  = 9;
  localparam int GAIN_W    = 16;
  localparam int LIMIT_W   = 8;
  localparam int ELAPSED_W = 16;
  localparam int MS_W      = 11;
  localparam int ERR_W     = 15;   // signed distance error
  localparam int ABS_W     = 14;
  localparam int INTEG_W   = 24;   // error integral, error * ms
  localparam int LIM_W     = 22;   // integral_limit * 16000
  localparam int DT_W      = 10;
  localparam int E125_W    = 22;   // error * 125
  localparam int KP_SHIFT  = 11;   // 256000 = 125 << 11
  localparam int ACC_W     = 49;   // PI sum before scaling
  localparam int DIV_SHIFT = 20;   // 1048576000 = 1000 << 20
  localparam int NUM_W     = 28;   // |sum| >> 20
  localparam int QUO_W     = 19;
  localparam int REM_W     = 10;
  localparam int CNT_W     = 5;
  localparam int SPEED_W   = 10;
  localparam int PULSE_W   = 11;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;

  localparam logic [MS_W-1:0]    MS_SAT      = 11'd2047;
  localparam logic [DT_W-1:0]    DT_MAX      = 10'd1000;
  localparam logic [DT_W-1:0]    DT_DEFAULT  = 10'd100;
  localparam logic [REM_W:0]     DIVISOR     = 11'd1000;
  localparam logic [PULSE_W:0]   PULSE_MID   = 12'd1500;

  // Register reset values
  localparam logic [DIST_W-1:0]   RST_TARGET  = 13'd240;
  localparam logic [TOL_W-1:0]    RST_TOL     = 10'd16;
  localparam logic [TOL_W-1:0]    RST_RECHECK = 10'd24;
  localparam logic [SPDCFG_W-1:0] RST_MIN     = 9'd100;
  localparam logic [SPDCFG_W-1:0] RST_MAX     = 9'd180;
  localparam logic [GAIN_W-1:0]   RST_KP      = 16'd1024;
  localparam logic [GAIN_W-1:0]   RST_KI      = 16'd6554;
  localparam logic [LIMIT_W-1:0]  RST_LIMIT   = 8'd50;

  // Register index, word address bits [4:2]
  typedef enum logic [2:0] {
    REG_TARGET  = 3'd0,
    REG_TOL     = 3'd1,
    REG_RECHECK = 3'd2,
    REG_MIN     = 3'd3,
    REG_MAX     = 3'd4,
    REG_KP      = 3'd5,
    REG_KI      = 3'd6,
    REG_LIMIT   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [DIST_W-1:0]   target;
    logic [TOL_W-1:0]    tolerance;
    logic [TOL_W-1:0]    recheck;
    logic [SPDCFG_W-1:0] speed_floor;
    logic [SPDCFG_W-1:0] speed_cap;
    logic [GAIN_W-1:0]   kp;
    logic [GAIN_W-1:0]   ki;
    logic [LIMIT_W-1:0]  limit;
  } cfg_t;

  // Command to the serial multiply-accumulate unit
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] nbits;
  } mac_cmd_t;

endpackage

@@ hw/rtl/dpsc_stream_if.sv @@
// Valid/ready channel interfaces for readings in and speed commands out.
// Depends on dpsc_pkg for field widths.
`timescale 1ns / 1ps

interface dpsc_reading_if;
  logic                         valid;
  logic                         ready;
  logic [dpsc_pkg::DIST_W-1:0]    distance;
  logic                         distance_valid;
  logic [dpsc_pkg::ELAPSED_W-1:0] elapsed_ms;

  modport source (output valid, distance, distance_valid, elapsed_ms, input ready);
  modport sink   (input valid, distance, distance_valid, elapsed_ms, output ready);
endinterface

interface dpsc_result_if;
  logic                               valid;
  logic                               ready;
  logic signed [dpsc_pkg::SPEED_W-1:0] speed;
  logic [dpsc_pkg::PULSE_W-1:0]        left_pulse_us;
  logic [dpsc_pkg::PULSE_W-1:0]        right_pulse_us;
  logic                               at_target;
  logic                               no_reading;

  modport source (output valid, speed, left_pulse_us, right_pulse_us, at_target, no_reading,
                  input ready);
  modport sink   (input valid, speed, left_pulse_us, right_pulse_us, at_target, no_reading,
                  output ready);
endinterface

@@ hw/rtl/dpsc_cfg.sv @@
// APB configuration register file for the speed controller.
// Depends on dpsc_pkg (cfg_t, reg_idx_t, reset values).
`timescale 1ns / 1ps

module dpsc_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dpsc_pkg::ADDR_W-1:0]   paddr,
  input  logic [dpsc_pkg::DATA_W-1:0]   pwdata,
  output logic [dpsc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output dpsc_pkg::cfg_t                cfg
);

  dpsc_pkg::reg_idx_t idx;
  logic               wr;

  assign idx    = dpsc_pkg::reg_idx_t'(paddr[4:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target      <= dpsc_pkg::RST_TARGET;
      cfg.tolerance   <= dpsc_pkg::RST_TOL;
      cfg.recheck     <= dpsc_pkg::RST_RECHECK;
      cfg.speed_floor <= dpsc_pkg::RST_MIN;
      cfg.speed_cap   <= dpsc_pkg::RST_MAX;
      cfg.kp          <= dpsc_pkg::RST_KP;
      cfg.ki          <= dpsc_pkg::RST_KI;
      cfg.limit       <= dpsc_pkg::RST_LIMIT;
    end else if (wr) begin
      unique case (idx)
        dpsc_pkg::REG_TARGET:  cfg.target      <= pwdata[dpsc_pkg::DIST_W-1:0];
        dpsc_pkg::REG_TOL:     cfg.tolerance   <= pwdata[dpsc_pkg::TOL_W-1:0];
        dpsc_pkg::REG_RECHECK: cfg.recheck     <= pwdata[dpsc_pkg::TOL_W-1:0];
        dpsc_pkg::REG_MIN:     cfg.speed_floor <= pwdata[dpsc_pkg::SPDCFG_W-1:0];
        dpsc_pkg::REG_MAX:     cfg.speed_cap   <= pwdata[dpsc_pkg::SPDCFG_W-1:0];
        dpsc_pkg::REG_KP:      cfg.kp          <= pwdata[dpsc_pkg::GAIN_W-1:0];
        dpsc_pkg::REG_KI:      cfg.ki          <= pwdata[dpsc_pkg::GAIN_W-1:0];
        dpsc_pkg::REG_LIMIT:   cfg.limit       <= pwdata[dpsc_pkg::LIMIT_W-1:0];
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      dpsc_pkg::REG_TARGET:  prdata = 32'(cfg.target);
      dpsc_pkg::REG_TOL:     prdata = 32'(cfg.tolerance);
      dpsc_pkg::REG_RECHECK: prdata = 32'(cfg.recheck);
      dpsc_pkg::REG_MIN:     prdata = 32'(cfg.speed_floor);
      dpsc_pkg::REG_MAX:     prdata = 32'(cfg.speed_cap);
      dpsc_pkg::REG_KP:      prdata = 32'(cfg.kp);
      dpsc_pkg::REG_KI:      prdata = 32'(cfg.ki);
      dpsc_pkg::REG_LIMIT:   prdata = 32'(cfg.limit);
    endcase
  end

endmodule

@@ hw/rtl/dpsc_mac.sv @@
// Bit-serial signed multiply-accumulate: one multiplier bit per cycle.
// acc = init + mcand * mplier[nbits-1:0]. Depends on dpsc_pkg.
`timescale 1ns / 1ps

module dpsc_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  dpsc_pkg::mac_cmd_t                  cmd,
  input  logic signed [dpsc_pkg::ACC_W-1:0]   mcand,
  input  logic [dpsc_pkg::GAIN_W-1:0]         mplier,
  input  logic signed [dpsc_pkg::ACC_W-1:0]   init,
  output logic signed [dpsc_pkg::ACC_W-1:0]   acc,
  output logic                                done
);

  logic signed [dpsc_pkg::ACC_W-1:0] m;
  logic [dpsc_pkg::GAIN_W-1:0]       q;
  logic [dpsc_pkg::CNT_W-1:0]        cnt;
  logic                              busy;

  // Step counter and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= cmd.nbits;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == dpsc_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift-add datapath: multiplicand moves left, multiplier bits drain from the LSB
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      m   <= mcand;
      q   <= mplier;
      acc <= init;
    end else if (busy) begin
      if (q[0]) acc <= acc + m;
      m <= m <<< 1;
      q <= q >> 1;
    end
  end

endmodule

@@ hw/rtl/dpsc_div.sv @@
// Bit-serial restoring divider by the constant 1000, one quotient bit per cycle.
// Depends on dpsc_pkg (NUM_W, REM_W, DIVISOR).
`timescale 1ns / 1ps

module dpsc_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [dpsc_pkg::NUM_W-1:0]    dividend,
  output logic [dpsc_pkg::NUM_W-1:0]    quot,
  output logic                          done
);

  logic [dpsc_pkg::REM_W-1:0] rem;
  logic [dpsc_pkg::REM_W:0]   trial;
  logic                       ge;
  logic [dpsc_pkg::REM_W:0]   diff;
  logic [dpsc_pkg::CNT_W-1:0] cnt;
  logic                       busy;

  // Next dividend bit joins the remainder; subtract when it fits
  assign trial = {rem, quot[dpsc_pkg::NUM_W-1]};
  assign ge    = trial >= dpsc_pkg::DIVISOR;
  assign diff  = trial - dpsc_pkg::DIVISOR;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= dpsc_pkg::CNT_W'(dpsc_pkg::NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == dpsc_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Dividend shifts out the top while quotient bits fill in from the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
    end else if (busy) begin
      quot <= {quot[dpsc_pkg::NUM_W-2:0], ge};
      rem  <= ge ? diff[dpsc_pkg::REM_W-1:0] : trial[dpsc_pkg::REM_W-1:0];
    end
  end

endmodule

@@ hw/rtl/distance_pi_speed_controller_unit.sv @@
// Distance PI speed controller: one speed command per accepted reading. Readings that
// need no PI update (no valid distance yet, reached, or inside the tolerance) go from
// the transfer straight to the output stage; a PI update first runs the bit-serial
// multiply-accumulate unit (error * dt over 10 multiplier bits, then the proportional
// and integral terms over 16 bits each) and the serial divide by 1000 over the 28-bit
// sum magnitude. No new reading is taken until the result has been loaded into the
// output register. A finished result waits in the output register while the next
// reading is taken. Depends on dpsc_pkg, the stream interfaces, dpsc_cfg, dpsc_mac,
// dpsc_div.
`timescale 1ns / 1ps

module distance_pi_speed_controller_unit (
  input  logic                          clk,
  input  logic                          rst,
  dpsc_reading_if.sink                  reading,
  dpsc_result_if.source                 result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dpsc_pkg::ADDR_W-1:0]   paddr,
  input  logic [dpsc_pkg::DATA_W-1:0]   pwdata,
  output logic [dpsc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  typedef enum logic [2:0] {
    S_IDLE, S_DT, S_CLAMP, S_KP, S_KI, S_ABS, S_DIV, S_DONE
  } state_t;

  state_t state;

  dpsc_pkg::cfg_t     cfg;
  dpsc_pkg::mac_cmd_t mac_cmd;

  // Controller state
  logic [dpsc_pkg::DIST_W-1:0]         lvd;
  logic signed [dpsc_pkg::INTEG_W-1:0] integral;
  logic [dpsc_pkg::MS_W-1:0]           ms;
  logic                                reached;

  // Per-item working registers
  logic signed [dpsc_pkg::ERR_W-1:0]   err;
  logic                                neg;
  logic signed [dpsc_pkg::SPEED_W-1:0] res_speed;
  logic                                res_at;
  logic                                res_nr;

  logic                                in_xfer;
  logic                                rd_ok;
  logic [dpsc_pkg::ELAPSED_W:0]        ms_sum;
  logic [dpsc_pkg::MS_W-1:0]           ms_next;
  logic [dpsc_pkg::DIST_W-1:0]         lvd_next;
  logic signed [dpsc_pkg::ERR_W-1:0]   rc_diff, rc_neg, err_new, err_neg;
  logic [dpsc_pkg::ABS_W-1:0]          rc_abs, err_abs;
  logic                                rc_out, tol_in, pi_go;
  logic [dpsc_pkg::DT_W-1:0]           dt_sel;

  logic signed [dpsc_pkg::E125_W-1:0]  err_x, e125;
  logic [dpsc_pkg::LIM_W-1:0]          lim;
  logic signed [dpsc_pkg::ACC_W-1:0]   lim_pos, lim_neg, acc_clamp, acc_mag;

  logic signed [dpsc_pkg::ACC_W-1:0]   mac_mcand, mac_init, mac_acc;
  logic [dpsc_pkg::GAIN_W-1:0]         mac_mplier;
  logic                                mac_done;
  logic                                div_start, div_done;
  logic [dpsc_pkg::NUM_W-1:0]          div_quot;

  logic [dpsc_pkg::QUO_W-1:0]          q, q_min, q_max, lifted;
  logic [dpsc_pkg::SPDCFG_W-1:0]       mag;
  logic signed [dpsc_pkg::SPEED_W-1:0] mag_s, speed_fin;
  logic signed [dpsc_pkg::PULSE_W:0]   spd_x, left_sum, right_sum;

  dpsc_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  dpsc_mac u_mac (
    .clk, .rst, .cmd(mac_cmd), .mcand(mac_mcand), .mplier(mac_mplier), .init(mac_init),
    .acc(mac_acc), .done(mac_done)
  );

  dpsc_div u_div (
    .clk, .rst, .start(div_start), .dividend(acc_mag[dpsc_pkg::ACC_W-2:dpsc_pkg::DIV_SHIFT]),
    .quot(div_quot), .done(div_done)
  );

  assign reading.ready = (state == S_IDLE);
  assign in_xfer       = reading.valid && reading.ready;

  // Item intake: time accumulation, last valid distance, error and deadband checks
  assign rd_ok    = reading.distance_valid && (reading.distance != '0);
  assign ms_sum   = {6'b0, ms} + {1'b0, reading.elapsed_ms};
  assign ms_next  = (ms_sum > {6'b0, dpsc_pkg::MS_SAT}) ? dpsc_pkg::MS_SAT
                                                        : ms_sum[dpsc_pkg::MS_W-1:0];
  assign lvd_next = rd_ok ? reading.distance : lvd;

  assign rc_diff = $signed({2'b0, reading.distance}) - $signed({2'b0, cfg.target});
  assign rc_neg  = -rc_diff;
  assign rc_abs  = rc_diff[dpsc_pkg::ERR_W-1] ? rc_neg[dpsc_pkg::ABS_W-1:0]
                                              : rc_diff[dpsc_pkg::ABS_W-1:0];
  assign rc_out  = rd_ok && (rc_abs > {4'b0, cfg.recheck});

  assign err_new = $signed({2'b0, lvd_next}) - $signed({2'b0, cfg.target});
  assign err_neg = -err_new;
  assign err_abs = err_new[dpsc_pkg::ERR_W-1] ? err_neg[dpsc_pkg::ABS_W-1:0]
                                              : err_new[dpsc_pkg::ABS_W-1:0];
  assign tol_in  = err_abs <= {4'b0, cfg.tolerance};

  assign pi_go  = in_xfer && !reached && (lvd_next != '0) && !tol_in;
  assign dt_sel = ((ms_next == '0) || (ms_next > {1'b0, dpsc_pkg::DT_MAX}))
                  ? dpsc_pkg::DT_DEFAULT : ms_next[dpsc_pkg::DT_W-1:0];

  // error * 125 (proportional scale 256000 = 125 << 11)
  assign err_x = {{(dpsc_pkg::E125_W-dpsc_pkg::ERR_W){err[dpsc_pkg::ERR_W-1]}}, err};
  assign e125  = (err_x <<< 7) - (err_x <<< 2) + err_x;

  // Anti-windup limit: limit * 16000 = limit * (2^14 - 2^8 - 2^7)
  assign lim = {cfg.limit, 14'b0} - {6'b0, cfg.limit, 8'b0} - {7'b0, cfg.limit, 7'b0};
  assign lim_pos = $signed({{(dpsc_pkg::ACC_W-dpsc_pkg::LIM_W){1'b0}}, lim});
  assign lim_neg = -lim_pos;
  assign acc_clamp = (mac_acc > lim_pos) ? lim_pos :
                     (mac_acc < lim_neg) ? lim_neg : mac_acc;

  // Magnitude of the PI sum, truncation toward zero after the divide
  assign acc_mag = mac_acc[dpsc_pkg::ACC_W-1] ? -mac_acc : mac_acc;

  // Minimum lift, then clamp (clamp wins)
  assign q      = div_quot[dpsc_pkg::QUO_W-1:0];
  assign q_min  = {10'b0, cfg.speed_floor};
  assign q_max  = {10'b0, cfg.speed_cap};
  assign lifted = ((q != '0) && (q < q_min)) ? q_min : q;
  assign mag    = (lifted > q_max) ? cfg.speed_cap : lifted[dpsc_pkg::SPDCFG_W-1:0];
  assign mag_s  = $signed({1'b0, mag});
  assign speed_fin = neg ? -mag_s : mag_s;

  // Servo pulses around 1500 us
  assign spd_x     = {{2{res_speed[dpsc_pkg::SPEED_W-1]}}, res_speed};
  assign left_sum  = $signed(dpsc_pkg::PULSE_MID) + spd_x;
  assign right_sum = $signed(dpsc_pkg::PULSE_MID) - spd_x;

  // Operand selection for the serial MAC and divider
  always_comb begin
    mac_cmd    = '0;
    mac_mcand  = '0;
    mac_mplier = '0;
    mac_init   = '0;
    div_start  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (pi_go) begin
          mac_cmd.start = 1'b1;
          mac_cmd.nbits = dpsc_pkg::CNT_W'(dpsc_pkg::DT_W);
          mac_mcand  = {{(dpsc_pkg::ACC_W-dpsc_pkg::ERR_W){err_new[dpsc_pkg::ERR_W-1]}},
                        err_new};
          mac_mplier = {6'b0, dt_sel};
          mac_init   = {{(dpsc_pkg::ACC_W-dpsc_pkg::INTEG_W){integral[dpsc_pkg::INTEG_W-1]}},
                        integral};
        end
      end
      S_CLAMP: begin
        mac_cmd.start = 1'b1;
        mac_cmd.nbits = dpsc_pkg::CNT_W'(dpsc_pkg::GAIN_W);
        mac_mcand  = {{(dpsc_pkg::ACC_W-dpsc_pkg::E125_W-dpsc_pkg::KP_SHIFT)
                        {e125[dpsc_pkg::E125_W-1]}}, e125, {dpsc_pkg::KP_SHIFT{1'b0}}};
        mac_mplier = cfg.kp;
      end
      S_KP: begin
        if (mac_done) begin
          mac_cmd.start = 1'b1;
          mac_cmd.nbits = dpsc_pkg::CNT_W'(dpsc_pkg::GAIN_W);
          mac_mcand  = {{(dpsc_pkg::ACC_W-dpsc_pkg::INTEG_W){integral[dpsc_pkg::INTEG_W-1]}},
                        integral};
          mac_mplier = cfg.ki;
          mac_init   = mac_acc;
        end
      end
      S_ABS:   div_start = 1'b1;
      default: ;
    endcase
  end

  // Sequencer, controller state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      lvd          <= '0;
      integral     <= '0;
      ms           <= '0;
      reached      <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      // output register empties on a transfer unless a new result is loaded below
      if (result.valid && result.ready && (state != S_DONE)) result.valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            lvd       <= lvd_next;
            res_speed <= '0;
            if (reached) begin
              if (rc_out) reached <= 1'b0;
              ms     <= ms_next;
              res_nr <= 1'b0;
              res_at <= !rc_out;
              state  <= S_DONE;
            end else if (lvd_next == '0) begin
              ms     <= ms_next;
              res_nr <= 1'b1;
              res_at <= 1'b0;
              state  <= S_DONE;
            end else if (tol_in) begin
              ms       <= ms_next;
              reached  <= 1'b1;
              integral <= '0;
              res_nr   <= 1'b0;
              res_at   <= 1'b1;
              state    <= S_DONE;
            end else begin
              ms     <= '0;
              res_nr <= 1'b0;
              res_at <= 1'b0;
              err    <= err_new;
              state  <= S_DT;
            end
          end
        end
        S_DT:    if (mac_done) state <= S_CLAMP;
        S_CLAMP: begin
          integral <= acc_clamp[dpsc_pkg::INTEG_W-1:0];
          state    <= S_KP;
        end
        S_KP:    if (mac_done) state <= S_KI;
        S_KI:    if (mac_done) state <= S_ABS;
        S_ABS: begin
          neg   <= mac_acc[dpsc_pkg::ACC_W-1];
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            res_speed <= speed_fin;
            state     <= S_DONE;
          end
        end
        S_DONE: begin
          if (!result.valid || result.ready) begin
            result.valid          <= 1'b1;
            result.speed          <= res_speed;
            result.left_pulse_us  <= left_sum[dpsc_pkg::PULSE_W-1:0];
            result.right_pulse_us <= right_sum[dpsc_pkg::PULSE_W-1:0];
            result.at_target      <= res_at;
            result.no_reading     <= res_nr;
            state                 <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/dpsc_check.sv @@
// Port-level checks for the speed controller, attached by bind.
// Depends on dpsc_pkg widths and distance_pi_speed_controller_unit.
`timescale 1ns / 1ps

module dpsc_check (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic signed [dpsc_pkg::SPEED_W-1:0] speed,
  input logic [dpsc_pkg::PULSE_W-1:0]        left_pulse_us,
  input logic [dpsc_pkg::PULSE_W-1:0]        right_pulse_us,
  input logic                                at_target,
  input logic                                no_reading
);

  // One reading in flight: a transfer is never followed by another the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !(in_valid && in_ready))
    else $error("back-to-back reading transfers");

  // Pulses are mirrored around 1500 us
  a_pulse_mirror: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, left_pulse_us} + {1'b0, right_pulse_us} == 12'd3000))
    else $error("left and right pulses not mirrored");

  // Stop without a reading
  a_no_reading_stop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && no_reading) |-> (speed == '0 && !at_target))
    else $error("no_reading with nonzero speed or reached");

  // Stop at target
  a_target_stop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && at_target) |-> (speed == '0 && !no_reading))
    else $error("at_target with nonzero speed");

endmodule

bind distance_pi_speed_controller_unit dpsc_check u_dpsc_check (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (reading.valid),
  .in_ready       (reading.ready),
  .out_valid      (result.valid),
  .speed          (result.speed),
  .left_pulse_us  (result.left_pulse_us),
  .right_pulse_us (result.right_pulse_us),
  .at_target      (result.at_target),
  .no_reading     (result.no_reading)
);
